// ===== sv/ekp_pkg.sv =====
// Package with the item, result and state types of the engine key panel controller.
`default_nettype none

package ekp_pkg;

   // Input transaction kinds carried on the request tuser bit.
   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_ENGINE_INSTANCE = 1'b0;
   localparam logic CSR_BEEP_TICKS      = 1'b1;

   // Reset value of the buzzer duration.
   localparam logic [15:0] BEEP_TICKS_RESET = 16'd200;

   // One input item.
   typedef struct packed {
      logic       cmd;
      logic [7:0] seq_id;
      logic       down_main;
      logic       down_light;
      logic       down_start;
      logic       down_stop;
      logic       chg_main;
      logic       chg_light;
      logic       chg_start;
      logic       chg_stop;
   } item_type;

   // One result item.
   typedef struct packed {
      logic       ack_send;
      logic [7:0] ack_id;
      logic       repeat_dropped;
      logic       state_send;
      logic [7:0] state_instance;
      logic       relay_main;
      logic       relay_light;
      logic       relay_start;
      logic       relay_stop;
      logic       buzzer_on;
      logic       running_flag;
   } result_type;

   // Panel state kept between items.
   typedef struct packed {
      logic        main_power;
      logic        light_state;
      logic        engine_running;
      logic        start_busy;
      logic        stop_busy;
      logic        start_drive;
      logic        stop_drive;
      logic [7:0]  prior_id;
      logic        prior_id_valid;
      logic [15:0] beep_remaining;
   } panel_state_type;

endpackage

`default_nettype wire

// ===== sv/engine_key_panel_controller.sv =====
// Top level of the engine key panel controller: input register, panel state and result register.
`default_nettype none

//  Channel  Ports                         Direction  Contents
//  req      req_tvalid/tready/tdata/tuser in         key message or tick
//  rsp      rsp_tvalid/tready/tdata       out        one result per item
//  csr      csr_we/csr_addr/csr_wdata     in         engine_instance, beep_ticks
//
// One item per cycle is accepted while rsp is not stalled; each result passes through
// the input register, then the panel logic into the result register, before it is
// driven on rsp.
// Reset clears the panel state and both valid flags and returns the configuration
// registers to their reset values.
// A stalled rsp side holds the result register; the input register takes an item
// only while it is empty or the result register can move on.

module engine_key_panel_controller (
   input  wire         clock,
   input  wire         reset,
   // Request: tdata = seq_id[7:0], down_main, down_light, down_start, down_stop,
   // chg_main, chg_light, chg_start, chg_stop (bit 15).
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,
   // Request tuser: cmd (0 key message, 1 tick).
   input  wire         req_tuser,
   // Result: tdata = ack_send, ack_id[8:1], repeat_dropped, state_send,
   // state_instance[18:11], relay_main, relay_light, relay_start, relay_stop,
   // buzzer_on, running_flag (bit 24), zeros above.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,
   // Configuration write port.
   input  wire         csr_we,
   input  wire         csr_addr,
   input  wire  [15:0] csr_wdata
);
   import ekp_pkg::*;

   logic [7:0]      engine_instance_reg_ff;
   logic [15:0]     beep_ticks_ff;
   logic            in_valid_ff;
   item_type        in_item_ff;
   item_type        in_item_in;
   logic            out_valid_ff;
   result_type      out_item_ff;
   result_type      out_item_in;
   panel_state_type state_ff;
   panel_state_type state_in;
   logic            out_ready;
   logic            advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         engine_instance_reg_ff <= 8'd0;
         beep_ticks_ff          <= BEEP_TICKS_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_ENGINE_INSTANCE) begin
            engine_instance_reg_ff <= csr_wdata[7:0];
         end
         if (csr_addr == CSR_BEEP_TICKS) begin
            beep_ticks_ff <= csr_wdata;
         end
      end
   end

   // Unpack the request transaction.
   always_comb begin
      in_item_in.cmd        = req_tuser;
      in_item_in.seq_id     = req_tdata[7:0];
      in_item_in.down_main  = req_tdata[8];
      in_item_in.down_light = req_tdata[9];
      in_item_in.down_start = req_tdata[10];
      in_item_in.down_stop  = req_tdata[11];
      in_item_in.chg_main   = req_tdata[12];
      in_item_in.chg_light  = req_tdata[13];
      in_item_in.chg_start  = req_tdata[14];
      in_item_in.chg_stop   = req_tdata[15];
   end

   // Flow control: the result register moves when empty or taken.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   // Panel rules for the item in the input register.
   ekp_step u_step (
      .item            (in_item_ff),
      .cur             (state_ff),
      .engine_instance (engine_instance_reg_ff),
      .beep_ticks      (beep_ticks_ff),
      .nxt             (state_in),
      .result          (out_item_in)
   );

   // Panel state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   // Pack the result transaction.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_item_ff.running_flag,
                        out_item_ff.buzzer_on,
                        out_item_ff.relay_stop,
                        out_item_ff.relay_start,
                        out_item_ff.relay_light,
                        out_item_ff.relay_main,
                        out_item_ff.state_instance,
                        out_item_ff.state_send,
                        out_item_ff.repeat_dropped,
                        out_item_ff.ack_id,
                        out_item_ff.ack_send};

endmodule

`default_nettype wire

// ===== sv/ekp_step.sv =====
// Next-state and result logic for one item of the engine key panel controller.
`default_nettype none

module ekp_step (
   input  wire  ekp_pkg::item_type        item,
   input  wire  ekp_pkg::panel_state_type cur,
   input  wire  [7:0]                     engine_instance,
   input  wire  [15:0]                    beep_ticks,
   output ekp_pkg::panel_state_type       nxt,
   output ekp_pkg::result_type            result
);
   import ekp_pkg::*;

   logic [15:0] refuse_load;
   logic        state_msg;
   logic        dropped;

   // A zero duration still gives one tick of buzzer.
   assign refuse_load = (beep_ticks == 16'd0) ? 16'd1 : beep_ticks;

   // Walk the item through the panel rules in order.
   always_comb begin
      nxt       = cur;
      state_msg = 1'b0;
      dropped   = 1'b0;
      if (item.cmd == CMD_TICK) begin
         if (cur.beep_remaining != 16'd0) begin
            nxt.beep_remaining = cur.beep_remaining - 16'd1;
         end
      end else if (cur.prior_id_valid && (item.seq_id == cur.prior_id)) begin
         dropped = 1'b1;
      end else begin
         nxt.prior_id       = item.seq_id;
         nxt.prior_id_valid = 1'b1;
         if (item.chg_main && item.down_main) begin
            // Main key toggles power unless the engine is running.
            if (!cur.main_power) begin
               nxt.main_power = 1'b1;
               state_msg      = 1'b1;
            end else if (cur.engine_running) begin
               nxt.beep_remaining = refuse_load;
            end else begin
               nxt.main_power  = 1'b0;
               nxt.light_state = 1'b0;
               nxt.start_drive = 1'b0;
               nxt.stop_drive  = 1'b0;
               state_msg       = 1'b1;
            end
         end else if (cur.main_power) begin
            if (item.chg_light && item.down_light) begin
               nxt.light_state = !cur.light_state;
            end
            // Start key: press engages the starter, release marks running.
            if (item.chg_start) begin
               if (item.down_start) begin
                  if (nxt.engine_running || nxt.stop_busy || nxt.start_busy) begin
                     nxt.beep_remaining = refuse_load;
                  end else begin
                     nxt.start_busy  = 1'b1;
                     nxt.start_drive = 1'b1;
                  end
               end else begin
                  nxt.start_busy     = 1'b0;
                  nxt.start_drive    = 1'b0;
                  nxt.engine_running = 1'b1;
               end
            end
            // Stop key: press engages the solenoid, release marks stopped.
            if (item.chg_stop) begin
               if (item.down_stop) begin
                  if (!nxt.engine_running || nxt.stop_busy || nxt.start_busy) begin
                     nxt.beep_remaining = refuse_load;
                  end else begin
                     nxt.stop_busy  = 1'b1;
                     nxt.stop_drive = 1'b1;
                  end
               end else begin
                  nxt.stop_busy      = 1'b0;
                  nxt.stop_drive     = 1'b0;
                  nxt.engine_running = 1'b0;
               end
            end
         end
      end
   end

   // Result fields follow the state after this item.
   always_comb begin
      result.ack_send       = (item.cmd == CMD_KEY);
      result.ack_id         = (item.cmd == CMD_KEY) ? item.seq_id : 8'd0;
      result.repeat_dropped = dropped;
      result.state_send     = state_msg;
      result.state_instance = state_msg ? engine_instance : 8'd0;
      result.relay_main     = nxt.main_power;
      result.relay_light    = nxt.light_state;
      result.relay_start    = nxt.start_drive;
      result.relay_stop     = nxt.stop_drive;
      result.buzzer_on      = (nxt.beep_remaining != 16'd0);
      result.running_flag   = nxt.engine_running;
   end

endmodule

`default_nettype wire

// ===== tb/tb_engine_key_panel_controller.sv =====
// Self-checking testbench for the engine key panel controller: predictor, stimulus and checks.
`default_nettype none

module tb_engine_key_panel_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import ekp_pkg::*;

   // Key masks for building key messages, ordered main, light, start, stop.
   localparam logic [3:0] K_NONE  = 4'b0000;
   localparam logic [3:0] K_MAIN  = 4'b0001;
   localparam logic [3:0] K_LIGHT = 4'b0010;
   localparam logic [3:0] K_START = 4'b0100;
   localparam logic [3:0] K_STOP  = 4'b1000;

   localparam int ITEMS_PER_PHASE = 350;
   localparam int NUM_PHASES      = 5;
   localparam int LONG_HOLD       = 80;
   localparam int DRAIN_CYCLES    = 8;

   // Panel predictor and expected result store.
   class panel_scoreboard;
      panel_state_type st;
      logic [7:0]      instance_num;
      logic [15:0]     beep_len;
      result_type      expected_q[$];
      int              mismatches;

      function new();
         st           = '0;
         instance_num = 8'd0;
         beep_len     = BEEP_TICKS_RESET;
         mismatches   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // A refusal restarts the buzzer; a zero length still gives one tick.
      function void sound_buzzer();
         st.beep_remaining = (beep_len != 16'd0) ? beep_len : 16'd1;
      endfunction

      // Work out the result of one accepted input transaction.
      function void note_item(item_type it);
         result_type r;
         logic       acked;
         logic       dropped;
         logic       state_msg;
         r         = '0;
         acked     = 1'b0;
         dropped   = 1'b0;
         state_msg = 1'b0;
         if (it.cmd == CMD_TICK) begin
            if (st.beep_remaining != 16'd0) begin
               st.beep_remaining = st.beep_remaining - 16'd1;
            end
         end else begin
            acked = 1'b1;
            if (st.prior_id_valid && it.seq_id == st.prior_id) begin
               dropped = 1'b1;
            end else begin
               st.prior_id       = it.seq_id;
               st.prior_id_valid = 1'b1;
               if (it.chg_main && it.down_main) begin
                  // Main press swallows every other key of the message.
                  if (!st.main_power) begin
                     st.main_power = 1'b1;
                     state_msg     = 1'b1;
                  end else if (st.engine_running) begin
                     sound_buzzer();
                  end else begin
                     st.main_power  = 1'b0;
                     st.light_state = 1'b0;
                     st.start_drive = 1'b0;
                     st.stop_drive  = 1'b0;
                     state_msg      = 1'b1;
                  end
               end else if (st.main_power) begin
                  if (it.chg_light && it.down_light) begin
                     st.light_state = !st.light_state;
                  end
                  if (it.chg_start) begin
                     if (it.down_start) begin
                        if (st.engine_running || st.stop_busy || st.start_busy) begin
                           sound_buzzer();
                        end else begin
                           st.start_busy  = 1'b1;
                           st.start_drive = 1'b1;
                        end
                     end else begin
                        st.start_busy     = 1'b0;
                        st.start_drive    = 1'b0;
                        st.engine_running = 1'b1;
                     end
                  end
                  if (it.chg_stop) begin
                     if (it.down_stop) begin
                        if (!st.engine_running || st.stop_busy || st.start_busy) begin
                           sound_buzzer();
                        end else begin
                           st.stop_busy  = 1'b1;
                           st.stop_drive = 1'b1;
                        end
                     end else begin
                        st.stop_busy      = 1'b0;
                        st.stop_drive     = 1'b0;
                        st.engine_running = 1'b0;
                     end
                  end
               end
            end
         end
         r.ack_send       = acked;
         r.ack_id         = acked ? it.seq_id : 8'd0;
         r.repeat_dropped = dropped;
         r.state_send     = state_msg;
         r.state_instance = state_msg ? instance_num : 8'd0;
         r.relay_main     = st.main_power;
         r.relay_light    = st.light_state;
         r.relay_start    = st.start_drive;
         r.relay_stop     = st.stop_drive;
         r.buzzer_on      = (st.beep_remaining != 16'd0);
         r.running_flag   = st.engine_running;
         expected_q.push_back(r);
      endfunction

      // One line per mismatch, and a count of them.
      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
         mismatches++;
      endtask

      task cmp_field(string what, logic [7:0] got, logic [7:0] want);
         if (got !== want) begin
            report_mismatch(what, {24'd0, got}, {24'd0, want});
         end
      endtask

      // Compare an accepted result transaction with the oldest expectation.
      task check_result(result_type got, logic [6:0] pad);
         result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", {7'd0, got}, 32'd0);
         end else begin
            want = expected_q.pop_front();
            cmp_field("ack_send", 8'(got.ack_send), 8'(want.ack_send));
            cmp_field("ack_id", got.ack_id, want.ack_id);
            cmp_field("repeat_dropped", 8'(got.repeat_dropped), 8'(want.repeat_dropped));
            cmp_field("state_send", 8'(got.state_send), 8'(want.state_send));
            cmp_field("state_instance", got.state_instance, want.state_instance);
            cmp_field("relay_main", 8'(got.relay_main), 8'(want.relay_main));
            cmp_field("relay_light", 8'(got.relay_light), 8'(want.relay_light));
            cmp_field("relay_start", 8'(got.relay_start), 8'(want.relay_start));
            cmp_field("relay_stop", 8'(got.relay_stop), 8'(want.relay_stop));
            cmp_field("buzzer_on", 8'(got.buzzer_on), 8'(want.buzzer_on));
            cmp_field("running_flag", 8'(got.running_flag), 8'(want.running_flag));
            cmp_field("padding", {1'b0, pad}, 8'd0);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = CMD_KEY;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_ENGINE_INSTANCE;
   logic [15:0] csr_wdata = '0;

   panel_scoreboard sb = new();

   logic        sender_burst = 1'b0;
   logic        long_hold_req = 1'b0;
   logic [7:0]  next_id = 8'd0;
   logic [7:0]  last_id = 8'd0;

   engine_key_panel_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic item_type make_key(logic [7:0] id, logic [3:0] down, logic [3:0] chg);
      item_type it;
      it.cmd        = CMD_KEY;
      it.seq_id     = id;
      it.down_main  = down[0];
      it.down_light = down[1];
      it.down_start = down[2];
      it.down_stop  = down[3];
      it.chg_main   = chg[0];
      it.chg_light  = chg[1];
      it.chg_start  = chg[2];
      it.chg_stop   = chg[3];
      return it;
   endfunction

   function automatic item_type make_tick();
      item_type it;
      it     = make_key(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)));
      it.cmd = CMD_TICK;
      return it;
   endfunction

   // Random item: mostly fresh key messages with plausible key activity,
   // plus ticks, repeated ids and pure noise.
   function automatic item_type make_random_item();
      int         r;
      logic [7:0] id;
      logic [3:0] down;
      logic [3:0] chg;
      r = $urandom_range(0, 99);
      if (r < 22) begin
         return make_tick();
      end
      if (r < 30) begin
         id = last_id;
      end else if (r < 35) begin
         id = 8'($urandom_range(0, 255));
      end else begin
         id      = next_id;
         next_id = next_id + 8'd1;
      end
      last_id = id;
      if (r >= 90) begin
         down = 4'($urandom_range(0, 15));
         chg  = 4'($urandom_range(0, 15));
      end else begin
         down = 4'($urandom_range(0, 15));
         chg  = K_NONE;
         if ($urandom_range(0, 99) < 9) begin
            chg[0]  = 1'b1;
            down[0] = 1'b1;
         end else begin
            down[0] = 1'b0;
            chg[0]  = ($urandom_range(0, 9) == 0);
         end
         chg[1] = ($urandom_range(0, 99) < 30);
         chg[2] = ($urandom_range(0, 99) < 35);
         chg[3] = ($urandom_range(0, 99) < 35);
      end
      return make_key(id, down, chg);
   endfunction

   // Offer one input transaction and wait until it is taken.
   task automatic send_item(item_type it);
      int gap;
      gap = sender_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {it.chg_stop, it.chg_start, it.chg_light, it.chg_main,
                     it.down_stop, it.down_start, it.down_light, it.down_main, it.seq_id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Write both registers while the block is idle.
   task automatic write_settings(logic [7:0] inst, logic [15:0] ticks);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_ENGINE_INSTANCE;
      csr_wdata <= {8'd0, inst};
      @(posedge clock);
      csr_addr  <= CSR_BEEP_TICKS;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.instance_num = inst;
      sb.beep_len     = ticks;
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Watch both channels; values sampled at the edge are the pre-edge values.
   always @(posedge clock) begin
      item_type   seen_item;
      result_type seen_result;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_item.cmd        = req_tuser;
            seen_item.seq_id     = req_tdata[7:0];
            seen_item.down_main  = req_tdata[8];
            seen_item.down_light = req_tdata[9];
            seen_item.down_start = req_tdata[10];
            seen_item.down_stop  = req_tdata[11];
            seen_item.chg_main   = req_tdata[12];
            seen_item.chg_light  = req_tdata[13];
            seen_item.chg_start  = req_tdata[14];
            seen_item.chg_stop   = req_tdata[15];
            sb.note_item(seen_item);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_result.ack_send       = rsp_tdata[0];
            seen_result.ack_id         = rsp_tdata[8:1];
            seen_result.repeat_dropped = rsp_tdata[9];
            seen_result.state_send     = rsp_tdata[10];
            seen_result.state_instance = rsp_tdata[18:11];
            seen_result.relay_main     = rsp_tdata[19];
            seen_result.relay_light    = rsp_tdata[20];
            seen_result.relay_start    = rsp_tdata[21];
            seen_result.relay_stop     = rsp_tdata[22];
            seen_result.buzzer_on      = rsp_tdata[23];
            seen_result.running_flag   = rsp_tdata[24];
            sb.check_result(seen_result, rsp_tdata[31:25]);
         end
      end
   end

   // Result side: ready runs broken by random stalls, and one long hold-off on request.
   initial begin
      int run;
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Stimulus: reset, directed sequence, then random phases under several settings.
   initial begin
      logic [7:0]  phase_inst;
      logic [15:0] phase_ticks;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings.
      send_item(make_tick());                                   // buzzer idle
      send_item(make_key(8'd0, K_NONE, K_NONE));                // first id zero is not a repeat
      send_item(make_key(8'd0, K_MAIN, K_MAIN));                // repeated id is dropped
      send_item(make_key(8'd1, K_START, K_START));              // main off: keys ignored
      send_item(make_key(8'd2, K_MAIN, K_MAIN));                // main on
      send_item(make_key(8'd3, K_LIGHT, K_LIGHT));              // light on
      send_item(make_key(8'd4, K_START, K_START));              // start pressed
      send_item(make_key(8'd5, K_STOP, K_STOP));                // stop refused
      send_item(make_key(8'd6, K_NONE, K_START));               // start released: running
      send_item(make_key(8'd7, K_MAIN, K_MAIN));                // main refused while running
      send_item(make_key(8'd8, K_STOP, K_STOP));                // stop pressed
      send_item(make_key(8'd9, 4'b1111, 4'b1111));              // main press hides the others
      send_item(make_key(8'd10, K_NONE, K_STOP));               // stop released
      send_item(make_key(8'd11, K_START | K_LIGHT, K_START));   // start pressed again
      send_item(make_key(8'd12, K_MAIN, K_MAIN));               // main off, start still busy
      send_item(make_key(8'd13, K_MAIN, K_MAIN));               // main on
      send_item(make_key(8'd14, K_START, K_START));             // refused: start busy
      send_item(make_key(8'd15, K_NONE, K_START));              // release: running
      send_item(make_key(8'd255, 4'b1111, 4'b1111));            // top id, main refused
      send_item(make_key(8'd254, K_NONE, 4'b1110));             // releases with main on
      repeat (3) send_item(make_tick());
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               phase_inst  = 8'hFF;
               phase_ticks = 16'd1;
            end
            1: begin
               phase_inst  = 8'h00;
               phase_ticks = 16'hFFFF;
            end
            2: begin
               phase_inst  = 8'($urandom_range(0, 255));
               phase_ticks = 16'd0;
            end
            3: begin
               phase_inst  = 8'($urandom_range(0, 255));
               phase_ticks = 16'($urandom_range(2, 30));
            end
            default: begin
               phase_inst  = 8'h5A;
               phase_ticks = 16'($urandom_range(1, 8));
            end
         endcase
         write_settings(phase_inst, phase_ticks);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 64 == 0) begin
               sender_burst = ($urandom_range(0, 3) == 0);
            end
            // Hold the result side off while items keep coming, so the block backs up.
            if (p == 0 && i == 50) begin
               sender_burst  = 1'b1;
               long_hold_req = 1'b1;
            end
            send_item(make_random_item());
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
